/* rtl/core/dote_pkg.sv */
// ----------------------------------------------------------------------------
// dote_pkg
// Shared constants, command word type and saturating Q32.32 helpers.
// ----------------------------------------------------------------------------
package dote_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int MAX_DIM     = 16;
	localparam int MAX_ROWS    = 16;

	localparam int ENTRY_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
	localparam int ROW_W   = $clog2(MAX_ROWS);
	localparam int SV_AW   = $clog2(MAX_ENTRIES * MAX_DIM);
	localparam int CF_AW   = $clog2(MAX_ENTRIES * MAX_ROWS * MAX_DIM);
	localparam int DIM_CAP = (MAX_DIM < 16) ? MAX_DIM : 16;

	localparam logic [2:0] ACT_HEADER = 3'd0;
	localparam logic [2:0] ACT_LDVAL  = 3'd1;
	localparam logic [2:0] ACT_LDCOEF = 3'd2;
	localparam logic [2:0] ACT_EVAL   = 3'd3;
	localparam logic [2:0] ACT_CLEAR  = 3'd4;

	localparam logic [2:0] RES_INTERP   = 3'd0;
	localparam logic [2:0] RES_POINT    = 3'd1;
	localparam logic [2:0] RES_EMPTY    = 3'd2;
	localparam logic [2:0] RES_ZERO_SEG = 3'd3;
	localparam logic [2:0] RES_FULL     = 3'd4;

	localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ONE_Q   = 64'h0000_0001_0000_0000;

	typedef struct packed {
		logic [2:0]       act;
		logic [63:0]      t;
		logic [63:0]      s0;
		logic [63:0]      s1;
		logic [63:0]      val;
		logic [ROW_W-1:0] ord;
		logic [ROW_W-1:0] row;
		logic [3:0]       comp;
	} cmd_t;

	function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63])
			return a[63] ? SAT_MIN : SAT_MAX;
		return s;
	endfunction

	function automatic logic [63:0] ssub(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = a - b;
		if (a[63] != b[63] && s[63] != a[63])
			return a[63] ? SAT_MIN : SAT_MAX;
		return s;
	endfunction

	function automatic logic [63:0] mag(input logic [63:0] a);
		return a[63] ? (~a + 64'd1) : a;
	endfunction

	function automatic logic [63:0] sat_fin(input logic [63:0] q, input logic neg,
			input logic ovf);
		if (neg)
			return (ovf || q > SAT_MIN) ? SAT_MIN : (~q + 64'd1);
		return (ovf || q > SAT_MAX) ? SAT_MAX : q;
	endfunction

	function automatic logic [SV_AW-1:0] sv_addr(input logic [ENTRY_W-1:0] e,
			input logic [3:0] c);
		return SV_AW'(e) * SV_AW'(MAX_DIM) + SV_AW'(c);
	endfunction

	function automatic logic [CF_AW-1:0] cf_addr(input logic [ENTRY_W-1:0] e,
			input logic [ROW_W-1:0] r, input logic [3:0] c);
		return CF_AW'(e) * CF_AW'(MAX_ROWS * MAX_DIM) + CF_AW'(r) * CF_AW'(MAX_DIM)
			+ CF_AW'(c);
	endfunction

endpackage

/* rtl/core/dote_ram.sv */
// ----------------------------------------------------------------------------
// dote_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dote_ram #(
	parameter int W = 64,
	parameter int D = 1024
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/dote_front.sv */
// ----------------------------------------------------------------------------
// dote_front
// Input side: takes words, drops unused actions and out-of-range loads,
// clamps the order and queues commands for the back end (two deep).
// ----------------------------------------------------------------------------
module dote_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         action,
	input  logic signed [63:0] time_req,
	input  logic signed [63:0] seg_start,
	input  logic signed [63:0] seg_end,
	input  logic [3:0]         order,
	input  logic [3:0]         row,
	input  logic [3:0]         component,
	input  logic signed [63:0] value,
	output dote_pkg::cmd_t     cmd,
	output logic               cmd_valid,
	input  logic               cmd_pop
);

	dote_pkg::cmd_t buf_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	dote_pkg::cmd_t nc;
	logic           keep, push, comp_ok, row_ok;

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = buf_q[rp_q];

	always_comb begin
		comp_ok = (32'(component) < dote_pkg::MAX_DIM);
		row_ok  = (32'(row) < dote_pkg::MAX_ROWS);
		case (action)
			dote_pkg::ACT_HEADER: keep = 1'b1;
			dote_pkg::ACT_LDVAL:  keep = comp_ok;
			dote_pkg::ACT_LDCOEF: keep = comp_ok && row_ok;
			dote_pkg::ACT_EVAL:   keep = 1'b1;
			dote_pkg::ACT_CLEAR:  keep = 1'b1;
			default:              keep = 1'b0;
		endcase
		nc.act  = action;
		nc.t    = time_req;
		nc.s0   = seg_start;
		nc.s1   = seg_end;
		nc.val  = value;
		nc.ord  = (32'(order) > dote_pkg::MAX_ROWS - 2) ?
			dote_pkg::ROW_W'(dote_pkg::MAX_ROWS - 2) : dote_pkg::ROW_W'(order);
		nc.row  = dote_pkg::ROW_W'(row);
		nc.comp = component;
	end

	assign push = in_valid && in_ready && keep;

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wp_q] <= nc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (cmd_pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end

endmodule

/* rtl/core/dote_div.sv */
// ----------------------------------------------------------------------------
// dote_div
// Serial Q32.32 divider: (num << 32) / den, one quotient bit per cycle,
// truncating toward zero and saturating.
// ----------------------------------------------------------------------------
module dote_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic        done,
	output logic [63:0] quo
);

	localparam int STEPS = 96;
	localparam int CW    = $clog2(STEPS + 1);

	logic [63:0]   mn_q, md_q, q_q;
	logic [64:0]   r_q;
	logic          neg_q, ovf_q, run_q, fin_q;
	logic [CW-1:0] cnt_q;
	logic [64:0]   r_sh;

	assign r_sh = {r_q[63:0], mn_q[63]};
	assign done = fin_q;
	assign quo  = dote_pkg::sat_fin(q_q, neg_q, ovf_q);

	always_ff @(posedge clk) begin
		if (start) begin
			mn_q  <= dote_pkg::mag(num);
			md_q  <= dote_pkg::mag(den);
			neg_q <= num[63] ^ den[63];
			r_q   <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (run_q) begin
			mn_q <= {mn_q[62:0], 1'b0};
			if (q_q[63])
				ovf_q <= 1'b1;
			if (r_sh >= {1'b0, md_q}) begin
				r_q <= r_sh - {1'b0, md_q};
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(STEPS - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

endmodule

/* rtl/core/dote_mul.sv */
// ----------------------------------------------------------------------------
// dote_mul
// Q32.32 multiplier: four 32x32 partial products accumulated in turn, then
// shift right 32, truncate toward zero and saturate.
// ----------------------------------------------------------------------------
module dote_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] prod
);

	logic [63:0]  ma_q, mb_q;
	logic [127:0] acc_q;
	logic         neg_q, run_q, fin_q;
	logic [1:0]   stp_q;
	logic [31:0]  pa, pb;
	logic [63:0]  pp;
	logic [127:0] pp_sh;

	always_comb begin
		pa = stp_q[1] ? ma_q[63:32] : ma_q[31:0];
		pb = (stp_q == 2'd1 || stp_q == 2'd3) ? mb_q[63:32] : mb_q[31:0];
		pp = 64'(pa) * 64'(pb);
		case (stp_q)
			2'd0:    pp_sh = {64'd0, pp};
			2'd3:    pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
	end

	assign done = fin_q;
	assign prod = dote_pkg::sat_fin(acc_q[95:32], neg_q, |acc_q[127:96]);

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= dote_pkg::mag(a);
			mb_q  <= dote_pkg::mag(b);
			neg_q <= a[63] ^ b[63];
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			stp_q <= 2'd0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				stp_q <= 2'd0;
			end else if (run_q) begin
				stp_q <= stp_q + 2'd1;
				if (stp_q == 2'd3) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

endmodule

/* rtl/core/dote_back.sv */
// ----------------------------------------------------------------------------
// dote_back
// Execution side: step table, bracket cache and bisection, stored-point
// readout and Horner evaluation, with the output word register.
// ----------------------------------------------------------------------------
module dote_back (
	input  logic                clk,
	input  logic                arst_n,
	input  dote_pkg::cmd_t      cmd,
	input  logic                cmd_valid,
	output logic                cmd_pop,
	input  logic [4:0]          dim_n,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          status,
	output logic [3:0]          out_component,
	output logic signed [63:0]  out_value,
	output logic                last
);

	localparam int EW = dote_pkg::ENTRY_W;
	localparam int RW = dote_pkg::ROW_W;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_EMIT = 4'd1;
	localparam logic [3:0] S_RL   = 4'd2;
	localparam logic [3:0] S_RH   = 4'd3;
	localparam logic [3:0] S_CHK  = 4'd4;
	localparam logic [3:0] S_BIS  = 4'd5;
	localparam logic [3:0] S_BISW = 4'd6;
	localparam logic [3:0] S_SV   = 4'd7;
	localparam logic [3:0] S_SVW  = 4'd8;
	localparam logic [3:0] S_SEG  = 4'd9;
	localparam logic [3:0] S_SEGW = 4'd10;
	localparam logic [3:0] S_DIV  = 4'd11;
	localparam logic [3:0] S_CY0  = 4'd12;
	localparam logic [3:0] S_CY0W = 4'd13;
	localparam logic [3:0] S_MUL  = 4'd14;
	localparam logic [3:0] S_MULW = 4'd15;
	localparam logic [3:0] S_OUT  = 4'd0;

	logic [3:0]                 state_q;
	logic                       out_st_q;
	logic [dote_pkg::CNT_W-1:0] count_q;
	logic [EW-1:0]              bl_q, bh_q, lo_q, hi_q, e_q;
	logic [63:0]                t_q, tl_q, y_q, tfrac_q, tmp_q;
	logic [RW-1:0]              k_q, row_q;
	logic [3:0]                 comp_q;
	logic [2:0]                 res_q;

	logic [EW-1:0]  mid, last_e, st_raddr;
	logic [EW:0]    mid_sum;
	logic [63:0]    st_rd, s0_rd, s1_rd, sv_rd, cf_rd, den, num;
	logic [RW-1:0]  ord_rd;
	logic           idle_cmd, hdr_we, sv_we, cf_we, full, cond, is_last, out_free;
	logic           div_start, div_done, mul_start, mul_done;
	logic [63:0]    div_q, mul_p;
	logic           emit;
	logic [2:0]     emit_st;
	logic [63:0]    emit_val;
	logic           emit_cmp;

	assign out_free = !out_valid || out_ready;
	assign idle_cmd = (state_q == S_IDLE) && !out_st_q && cmd_valid;
	assign cmd_pop  = idle_cmd;
	assign full     = (count_q == dote_pkg::CNT_W'(dote_pkg::MAX_ENTRIES));
	assign last_e   = EW'(count_q - 1'b1);
	assign hdr_we   = idle_cmd && cmd.act == dote_pkg::ACT_HEADER && !full;
	assign sv_we    = idle_cmd && cmd.act == dote_pkg::ACT_LDVAL && count_q != '0;
	assign cf_we    = idle_cmd && cmd.act == dote_pkg::ACT_LDCOEF && count_q != '0;
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = mid_sum[EW:1];
	assign is_last  = (5'(comp_q) + 5'd1 == dim_n);
	assign den      = dote_pkg::ssub(s1_rd, s0_rd);
	assign num      = dote_pkg::ssub(t_q, s0_rd);
	assign div_start = (state_q == S_SEGW) && !out_st_q && den != '0;
	assign mul_start = (state_q == S_MUL) && !out_st_q;
	assign cond = (dote_pkg::CNT_W'(bh_q) < count_q) && (bl_q <= bh_q)
		&& !($signed(t_q) < $signed(tl_q)) && !($signed(st_rd) < $signed(t_q));

	always_comb begin
		case (state_q)
			S_RL:    st_raddr = bl_q;
			S_RH:    st_raddr = bh_q;
			default: st_raddr = mid;
		endcase
	end

	dote_ram #(.W(64), .D(dote_pkg::MAX_ENTRIES)) u_st (
		.clk(clk), .we(hdr_we), .waddr(count_q[EW-1:0]), .wdata(cmd.t),
		.raddr(st_raddr), .rdata(st_rd));
	dote_ram #(.W(64), .D(dote_pkg::MAX_ENTRIES)) u_s0 (
		.clk(clk), .we(hdr_we), .waddr(count_q[EW-1:0]), .wdata(cmd.s0),
		.raddr(e_q), .rdata(s0_rd));
	dote_ram #(.W(64), .D(dote_pkg::MAX_ENTRIES)) u_s1 (
		.clk(clk), .we(hdr_we), .waddr(count_q[EW-1:0]), .wdata(cmd.s1),
		.raddr(e_q), .rdata(s1_rd));
	dote_ram #(.W(RW), .D(dote_pkg::MAX_ENTRIES)) u_ord (
		.clk(clk), .we(hdr_we), .waddr(count_q[EW-1:0]), .wdata(cmd.ord),
		.raddr(e_q), .rdata(ord_rd));
	dote_ram #(.W(64), .D(dote_pkg::MAX_ENTRIES * dote_pkg::MAX_DIM)) u_sv (
		.clk(clk), .we(sv_we), .waddr(dote_pkg::sv_addr(last_e, cmd.comp)),
		.wdata(cmd.val), .raddr(dote_pkg::sv_addr(e_q, comp_q)), .rdata(sv_rd));
	dote_ram #(.W(64),
		.D(dote_pkg::MAX_ENTRIES * dote_pkg::MAX_ROWS * dote_pkg::MAX_DIM)) u_cf (
		.clk(clk), .we(cf_we), .waddr(dote_pkg::cf_addr(last_e, cmd.row, cmd.comp)),
		.wdata(cmd.val), .raddr(dote_pkg::cf_addr(e_q, row_q, comp_q)), .rdata(cf_rd));

	dote_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(num), .den(den),
		.done(div_done), .quo(div_q));

	dote_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(y_q),
		.b((row_q == '0) ? tfrac_q : tmp_q), .done(mul_done), .prod(mul_p));

	// result words
	always_comb begin
		emit     = 1'b0;
		emit_st  = res_q;
		emit_val = '0;
		emit_cmp = 1'b0;
		if (out_st_q) begin
			emit     = out_free;
			emit_st  = dote_pkg::RES_INTERP;
			emit_val = y_q;
			emit_cmp = 1'b1;
		end else begin
			case (state_q)
				S_EMIT: emit = out_free;
				S_SVW: begin
					emit     = out_free;
					emit_st  = dote_pkg::RES_POINT;
					emit_val = sv_rd;
					emit_cmp = 1'b1;
				end
				default: emit = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status        <= emit_st;
			out_component <= emit_cmp ? comp_q : 4'd0;
			out_value     <= emit_val;
			last          <= emit_cmp ? is_last : 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			state_q   <= S_IDLE;
			out_st_q  <= 1'b0;
			count_q   <= '0;
			bl_q      <= '0;
			bh_q      <= '0;
		end else begin
			if (emit)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			if (out_st_q) begin
				if (emit) begin
					out_st_q <= 1'b0;
					if (is_last) begin
						state_q <= S_IDLE;
					end else begin
						comp_q  <= comp_q + 4'd1;
						row_q   <= RW'(k_q + 1'b1);
						state_q <= S_CY0;
					end
				end
			end else begin
				case (state_q)
					S_IDLE: begin
						if (idle_cmd) begin
							t_q <= cmd.t;
							case (cmd.act)
								dote_pkg::ACT_HEADER: begin
									if (full) begin
										res_q   <= dote_pkg::RES_FULL;
										state_q <= S_EMIT;
									end else begin
										count_q <= count_q + 1'b1;
									end
								end
								dote_pkg::ACT_CLEAR: begin
									count_q <= '0;
									bl_q    <= '0;
									bh_q    <= '0;
								end
								dote_pkg::ACT_EVAL: begin
									if (count_q == '0) begin
										res_q   <= dote_pkg::RES_EMPTY;
										state_q <= S_EMIT;
									end else begin
										state_q <= S_RL;
									end
								end
								default: state_q <= S_IDLE;
							endcase
						end
					end
					S_EMIT: begin
						if (emit)
							state_q <= S_IDLE;
					end
					S_RL: state_q <= S_RH;
					S_RH: begin
						tl_q    <= st_rd;
						state_q <= S_CHK;
					end
					S_CHK: begin
						comp_q <= 4'd0;
						if (cond && tl_q == t_q) begin
							e_q     <= bl_q;
							state_q <= S_SV;
						end else if (cond && st_rd == t_q) begin
							e_q     <= bh_q;
							state_q <= S_SV;
						end else if (cond) begin
							e_q     <= bh_q;
							state_q <= S_SEG;
						end else begin
							lo_q    <= '0;
							hi_q    <= last_e;
							state_q <= S_BIS;
						end
					end
					S_BIS: begin
						if (hi_q - lo_q > EW'(1)) begin
							state_q <= S_BISW;
						end else begin
							bl_q    <= lo_q;
							bh_q    <= hi_q;
							e_q     <= hi_q;
							state_q <= S_SEG;
						end
					end
					S_BISW: begin
						if ($signed(t_q) < $signed(st_rd))
							hi_q <= mid;
						else
							lo_q <= mid;
						state_q <= S_BIS;
					end
					S_SV: state_q <= S_SVW;
					S_SVW: begin
						if (emit) begin
							if (is_last) begin
								state_q <= S_IDLE;
							end else begin
								comp_q  <= comp_q + 4'd1;
								state_q <= S_SV;
							end
						end
					end
					S_SEG: state_q <= S_SEGW;
					S_SEGW: begin
						k_q   <= ord_rd;
						row_q <= RW'(ord_rd + 1'b1);
						if (den == '0) begin
							res_q   <= dote_pkg::RES_ZERO_SEG;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_DIV;
						end
					end
					S_DIV: begin
						if (div_done) begin
							tfrac_q <= div_q;
							tmp_q   <= dote_pkg::ssub(div_q, dote_pkg::ONE_Q);
							state_q <= S_CY0;
						end
					end
					S_CY0: state_q <= S_CY0W;
					S_CY0W: begin
						y_q     <= cf_rd;
						row_q   <= k_q;
						state_q <= S_MUL;
					end
					S_MUL: state_q <= S_MULW;
					S_MULW: begin
						if (mul_done) begin
							y_q <= dote_pkg::sadd(mul_p, cf_rd);
							if (row_q == '0) begin
								out_st_q <= 1'b1;
								state_q  <= S_OUT;
							end else begin
								row_q   <= row_q - 1'b1;
								state_q <= S_MUL;
							end
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

endmodule

/* rtl/core/dense_output_trajectory_eval.sv */
// ----------------------------------------------------------------------------
// dense_output_trajectory_eval
// Trajectory store with cached-bracket lookup and Hermite/Horner evaluation.
//
// Input channel (in_valid/in_ready) takes one word per action: append header,
// load state value, load coefficient, evaluate, clear. Output channel
// (out_valid/out_ready) returns the result words of an evaluate, one per
// component with last on the final one, or one status word.
// Header, load and clear words give no output, but a header on a full
// store gives one status word. Evaluate: a cached bracket check, then
// bisection steps (log2 of the entry count) on a miss, the segment read,
// the serial divider and per component the multiply-add loop on the
// shared multiplier; a stored point is read out per component. A two-deep
// command queue lets the input run ahead of the back end. A stalled
// receiver holds the output register and the back end waits.
// Reset clears the entry count, the bracket and the queue; the tables are
// not cleared. dimension_in_use is written over the APB port at address 0.
// ----------------------------------------------------------------------------
module dense_output_trajectory_eval (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         action,
	input  logic signed [63:0] time_req,
	input  logic signed [63:0] seg_start,
	input  logic signed [63:0] seg_end,
	input  logic [3:0]         order,
	input  logic [3:0]         row,
	input  logic [3:0]         component,
	input  logic signed [63:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [3:0]         out_component,
	output logic signed [63:0] out_value,
	output logic               last
);

	logic [4:0]     dim_q, dim_n;
	dote_pkg::cmd_t cmd;
	logic           cmd_valid, cmd_pop;

	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? {27'd0, dim_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dim_q <= 5'd1;
		else if (psel && penable && pwrite && paddr == 3'd0)
			dim_q <= pwdata[4:0];
	end

	always_comb begin
		if (dim_q == 5'd0)
			dim_n = 5'd1;
		else if (32'(dim_q) > dote_pkg::DIM_CAP)
			dim_n = 5'(dote_pkg::DIM_CAP);
		else
			dim_n = dim_q;
	end

	dote_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.action(action), .time_req(time_req), .seg_start(seg_start),
		.seg_end(seg_end), .order(order), .row(row), .component(component),
		.value(value), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop));

	dote_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cmd_valid(cmd_valid),
		.cmd_pop(cmd_pop), .dim_n(dim_n), .out_valid(out_valid),
		.out_ready(out_ready), .status(status), .out_component(out_component),
		.out_value(out_value), .last(last));

endmodule

/* rtl/core/dote_checker.sv */
// ----------------------------------------------------------------------------
// dote_port_checks
// Port-level checks on the output channel and the register port.
// ----------------------------------------------------------------------------
module dote_port_checks (
	input logic               clk,
	input logic               arst_n,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [2:0]         paddr,
	input logic [31:0]        pwdata,
	input logic [31:0]        prdata,
	input logic               out_valid,
	input logic               out_ready,
	input logic [2:0]         status,
	input logic [3:0]         out_component,
	input logic signed [63:0] out_value,
	input logic               last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(status))
		else $error("output word changed while stalled");

	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == dote_pkg::RES_EMPTY || status == dote_pkg::RES_ZERO_SEG
			|| status == dote_pkg::RES_FULL)
		|-> last && out_component == 4'd0 && out_value == 64'sd0)
		else $error("status word carries data");

	a_multi: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> (status == dote_pkg::RES_INTERP
			|| status == dote_pkg::RES_POINT))
		else $error("non-final word with status-only code");

	a_reg: assert property (@(posedge clk) disable iff (!arst_n)
		$past(psel && penable && pwrite && paddr == 3'd0) && paddr == 3'd0
		|-> prdata[4:0] == $past(pwdata[4:0]))
		else $error("register readback mismatch");

endmodule

bind dense_output_trajectory_eval dote_port_checks u_dote_port_checks (.*);

/* bench/dote_checker.sv */
// ----------------------------------------------------------------------------
// dote_checker
// Watches the APB port and both streams of the trajectory evaluator, keeps a
// shadow of its tables, works out the result words of every accepted word
// and compares them in order with what comes out.
// ----------------------------------------------------------------------------
module dote_checker
	import dote_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  action,
	input  logic [63:0] time_req,
	input  logic [63:0] seg_start,
	input  logic [63:0] seg_end,
	input  logic [3:0]  order,
	input  logic [3:0]  row,
	input  logic [3:0]  component,
	input  logic [63:0] value,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  status,
	input  logic [3:0]  out_component,
	input  logic [63:0] out_value,
	input  logic        last,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] DIM_ADDR = 3'd0;

	typedef struct {
		logic [2:0]  st;
		logic [3:0]  comp;
		logic [63:0] val;
		logic        lst;
	} traj_word_t;

	traj_word_t  results_due[$];
	traj_word_t  head;
	logic [4:0]  dim_reg = 5'd1;
	int          n_entries = 0;
	int          brk_lo = 0;
	int          brk_hi = 0;
	logic [63:0] step_t  [0:MAX_ENTRIES-1];
	logic [63:0] seg_lo  [0:MAX_ENTRIES-1];
	logic [63:0] seg_hi  [0:MAX_ENTRIES-1];
	int          ent_ord [0:MAX_ENTRIES-1];
	logic [63:0] st_val  [0:MAX_ENTRIES*MAX_DIM-1];
	logic [63:0] hcoef   [0:MAX_ENTRIES*MAX_ROWS*MAX_DIM-1];

	initial begin
		errors = 0;
		pending = 0;
	end

	function automatic logic [63:0] q_abs(input logic [63:0] a);
		return a[63] ? -a : a;
	endfunction

	function automatic logic [63:0] q_pack(input logic [63:0] q, input bit neg, input bit ovf);
		if (neg) begin
			if (ovf || q > 64'h8000_0000_0000_0000)
				return 64'h8000_0000_0000_0000;
			return -q;
		end
		if (ovf || q > 64'h7FFF_FFFF_FFFF_FFFF)
			return 64'h7FFF_FFFF_FFFF_FFFF;
		return q;
	endfunction

	function automatic logic [63:0] q_add(input logic [63:0] a, input logic [63:0] b);
		logic signed [64:0] s;
		s = $signed({a[63], a}) + $signed({b[63], b});
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF)
			return 64'h7FFF_FFFF_FFFF_FFFF;
		if (s < -65'sh0_8000_0000_0000_0000)
			return 64'h8000_0000_0000_0000;
		return s[63:0];
	endfunction

	function automatic logic [63:0] q_sub(input logic [63:0] a, input logic [63:0] b);
		logic signed [64:0] s;
		s = $signed({a[63], a}) - $signed({b[63], b});
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF)
			return 64'h7FFF_FFFF_FFFF_FFFF;
		if (s < -65'sh0_8000_0000_0000_0000)
			return 64'h8000_0000_0000_0000;
		return s[63:0];
	endfunction

	function automatic logic [63:0] q_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, q_abs(a)} * {64'd0, q_abs(b)};
		return q_pack(p[95:32], a[63] ^ b[63], p[127:96] != 0);
	endfunction

	function automatic logic [63:0] q_div(input logic [63:0] num, input logic [63:0] den);
		logic [127:0] quo;
		quo = {32'd0, q_abs(num), 32'd0} / {64'd0, q_abs(den)};
		return q_pack(quo[63:0], num[63] ^ den[63], quo[127:64] != 0);
	endfunction

	task automatic push_word(input logic [2:0] st, input int c, input logic [63:0] v,
			input bit l);
		traj_word_t w;
		w.st = st;
		w.comp = c[3:0];
		w.val = v;
		w.lst = l;
		results_due.insert(results_due.size(), w);
	endtask

	task automatic predict_trajectory();
		int n, e, k, i, j, lo, hi, mid;
		logic [63:0] den, tf, tm, y;
		n = (dim_reg < 1) ? 1 : (dim_reg > DIM_CAP) ? DIM_CAP : int'(dim_reg);
		case (action)
			ACT_HEADER: begin
				if (n_entries >= MAX_ENTRIES) begin
					push_word(RES_FULL, 0, 64'd0, 1'b1);
				end else begin
					e = n_entries;
					k = (order > MAX_ROWS - 2) ? MAX_ROWS - 2 : int'(order);
					step_t[e] = time_req;
					seg_lo[e] = seg_start;
					seg_hi[e] = seg_end;
					ent_ord[e] = k;
					for (i = 0; i < MAX_DIM; i++)
						st_val[e*MAX_DIM+i] = 64'd0;
					for (i = 0; i < MAX_ROWS * MAX_DIM; i++)
						hcoef[e*MAX_ROWS*MAX_DIM+i] = 64'd0;
					n_entries = e + 1;
				end
			end
			ACT_LDVAL, ACT_LDCOEF: begin
				if (n_entries != 0 && component < MAX_DIM) begin
					e = n_entries - 1;
					if (action == ACT_LDVAL)
						st_val[e*MAX_DIM+component] = value;
					else if (row < MAX_ROWS)
						hcoef[(e*MAX_ROWS+row)*MAX_DIM+component] = value;
				end
			end
			ACT_CLEAR: begin
				n_entries = 0;
				brk_lo = 0;
				brk_hi = 0;
			end
			ACT_EVAL: begin
				if (n_entries == 0) begin
					push_word(RES_EMPTY, 0, 64'd0, 1'b1);
				end else begin
					e = -1;
					if (brk_hi < n_entries && brk_lo <= brk_hi
							&& $signed(time_req) >= $signed(step_t[brk_lo])
							&& $signed(step_t[brk_hi]) >= $signed(time_req)) begin
						if (step_t[brk_lo] == time_req)
							e = brk_lo;
						else if (step_t[brk_hi] == time_req)
							e = brk_hi;
					end else begin
						lo = 0;
						hi = n_entries - 1;
						while (hi - lo > 1) begin
							mid = (lo + hi) / 2;
							if ($signed(time_req) < $signed(step_t[mid]))
								hi = mid;
							else
								lo = mid;
						end
						brk_lo = lo;
						brk_hi = hi;
					end
					if (e >= 0) begin
						for (i = 0; i < n; i++)
							push_word(RES_POINT, i, st_val[e*MAX_DIM+i], i + 1 == n);
					end else begin
						e = brk_hi;
						den = q_sub(seg_hi[e], seg_lo[e]);
						if (den == 0) begin
							push_word(RES_ZERO_SEG, 0, 64'd0, 1'b1);
						end else begin
							tf = q_div(q_sub(time_req, seg_lo[e]), den);
							tm = q_sub(tf, ONE_Q);
							k = ent_ord[e];
							for (i = 0; i < n; i++) begin
								y = hcoef[(e*MAX_ROWS+k+1)*MAX_DIM+i];
								for (j = 0; j < k; j++)
									y = q_add(q_mul(y, tm), hcoef[(e*MAX_ROWS+k-j)*MAX_DIM+i]);
								y = q_add(q_mul(y, tf), hcoef[(e*MAX_ROWS)*MAX_DIM+i]);
								push_word(RES_INTERP, i, y, i + 1 == n);
							end
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable && pwrite && pready && paddr == DIM_ADDR)
				dim_reg = pwdata[4:0];
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected word, got status=%0d comp=%0d value=%h last=%0b",
						$time, status, out_component, out_value, last);
				end else begin
					head = results_due.pop_front();
					if (head.st !== status || head.comp !== out_component
							|| head.val !== out_value || head.lst !== last) begin
						errors++;
						$display("%0t: mismatch, expected status=%0d comp=%0d value=%h last=%0b",
							$time, head.st, head.comp, head.val, head.lst);
						$display("%0t:           got status=%0d comp=%0d value=%h last=%0b",
							$time, status, out_component, out_value, last);
					end
				end
			end
			if (in_valid && in_ready)
				predict_trajectory();
			pending <= results_due.size();
		end
	end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the trajectory evaluator: directed words for the corner
// cases, then random phases over several dimensions with well-formed
// entries, queries and noise, bursty sender, stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dote_pkg::*;

	localparam logic [2:0] DIM_ADDR = 3'd0;
	localparam logic [2:0] ACT_SPARE5 = 3'd5;
	localparam logic [2:0] ACT_SPARE6 = 3'd6;
	localparam logic [2:0] ACT_SPARE7 = 3'd7;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [2:0]         action = '0;
	logic signed [63:0] time_req = '0;
	logic signed [63:0] seg_start = '0;
	logic signed [63:0] seg_end = '0;
	logic [3:0]         order = '0;
	logic [3:0]         row = '0;
	logic [3:0]         component = '0;
	logic signed [63:0] value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         status;
	logic [3:0]         out_component;
	logic signed [63:0] out_value;
	logic               last;
	int                 errors;
	int                 pending;

	int                 burst_left = 0;
	int                 ndim = 1;
	int                 last_j = 0;
	int                 rx_mode = 0;
	int                 rx_len = 0;
	logic signed [63:0] stimes[$];

	dense_output_trajectory_eval i_dut (.*);

	dote_checker i_chk (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (rx_len == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_len = $urandom_range(1, 40);
		end
		rx_len--;
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= 1'b0;
			default: out_ready <= rx_len[0];
		endcase
	end

	initial begin
		#120_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [63:0] rand_q();
		logic signed [63:0] x;
		x = $signed({$urandom, $urandom});
		case ($urandom_range(0, 9))
			0: return x;
			1: return SAT_MAX;
			2: return SAT_MIN;
			default: return x >>> 29;
		endcase
	endfunction

	task automatic put_word(input logic [2:0] a, input logic [63:0] t, input logic [63:0] s0,
			input logic [63:0] s1, input logic [3:0] o, input logic [3:0] r,
			input logic [3:0] c, input logic [63:0] v);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		action <= a;
		time_req <= t;
		seg_start <= s0;
		seg_end <= s1;
		order <= o;
		row <= r;
		component <= c;
		value <= v;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
	endtask

	task automatic put_simple(input logic [2:0] a, input logic [63:0] t);
		put_word(a, t, rand_q(), rand_q(), 4'($urandom), 4'($urandom), 4'($urandom),
			rand_q());
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic apb_write(input int v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= DIM_ADDR;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		ndim = (v[4:0] < 1) ? 1 : (v[4:0] > DIM_CAP) ? DIM_CAP : int'(v[4:0]);
	endtask

	// header followed by every value and coefficient that an evaluation may read
	task automatic build_entry(input logic [63:0] t, input logic [63:0] s0,
			input logic [63:0] s1, input logic [3:0] o);
		int k, r, c;
		put_word(ACT_HEADER, t, s0, s1, o, 4'($urandom), 4'($urandom), rand_q());
		k = (o > MAX_ROWS - 2) ? MAX_ROWS - 2 : int'(o);
		stimes.insert(stimes.size(), t);
		for (c = 0; c < ndim; c++)
			put_word(ACT_LDVAL, rand_q(), rand_q(), rand_q(), 4'($urandom), 4'($urandom),
				4'(c), rand_q());
		for (r = 0; r <= k + 1; r++)
			for (c = 0; c < ndim; c++)
				put_word(ACT_LDCOEF, rand_q(), rand_q(), rand_q(), 4'($urandom), 4'(r),
					4'(c), rand_q());
	endtask

	task automatic add_entry(input int maxord, input bit unsorted);
		logic signed [63:0] t, s0, s1;
		int o;
		if (unsorted || stimes.size() == 0)
			t = $signed({$urandom, $urandom}) >>> 20;
		else
			t = stimes[$] + $signed({32'd0, $urandom_range(32'h4000_0000, 32'hFFFF_FFFF)});
		s0 = (stimes.size() == 0) ? t - ONE_Q : stimes[$];
		s1 = t;
		case ($urandom_range(0, 11))
			0: s1 = s0;
			1: begin
				s0 = rand_q();
				s1 = rand_q();
			end
			default: ;
		endcase
		o = $urandom_range(0, maxord);
		build_entry(t, s0, s1, 4'(o));
	endtask

	task automatic query();
		int j, sz;
		logic signed [63:0] q, d;
		sz = stimes.size();
		j = $urandom_range(0, sz - 1);
		case ($urandom_range(0, 9))
			0, 1, 2: q = stimes[j];
			3: begin
				j = (last_j + 1 < sz) ? last_j + $urandom_range(0, 1) : sz - 1;
				q = stimes[j];
			end
			4, 5, 6: begin
				if (j + 1 < sz) begin
					d = (stimes[j+1] - stimes[j]) >>> 8;
					q = stimes[j] + d * $urandom_range(0, 255);
				end else begin
					q = stimes[j];
				end
			end
			7: q = stimes[0] - $signed({32'd0, $urandom});
			8: q = stimes[sz-1] + $signed({32'd0, $urandom});
			default: q = $signed({$urandom, $urandom});
		endcase
		last_j = j;
		put_simple(ACT_EVAL, q);
	endtask

	task automatic restart_store();
		put_simple(ACT_CLEAR, rand_q());
		stimes.delete();
		last_j = 0;
	endtask

	task automatic run_phase(input int dimv, input int nent, input int maxord,
			input bit unsorted, input int nitems);
		int i;
		drain();
		apb_write(dimv);
		restart_store();
		for (i = 0; i < nent; i++)
			add_entry(maxord, unsorted);
		for (i = 0; i < nitems; i++) begin
			case ($urandom_range(0, 19))
				0: begin
					case ($urandom_range(0, 2))
						0: put_simple(3'(ACT_SPARE5 + $urandom_range(0, 2)), rand_q());
						1: put_word(ACT_LDCOEF, rand_q(), rand_q(), rand_q(), 4'($urandom),
							4'($urandom), 4'($urandom), rand_q());
						default: put_word(ACT_LDVAL, rand_q(), rand_q(), rand_q(),
							4'($urandom), 4'($urandom), 4'($urandom), rand_q());
					endcase
				end
				1: add_entry(maxord, unsorted);
				2: drain();
				3: begin
					restart_store();
					put_simple(ACT_EVAL, rand_q());
					add_entry(maxord, unsorted);
					add_entry(maxord, unsorted);
				end
				default: query();
			endcase
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty store, ignored loads, spare actions
		put_simple(ACT_EVAL, 64'd0);
		put_simple(ACT_LDVAL, 64'd0);
		put_simple(ACT_LDCOEF, 64'd0);
		put_simple(ACT_SPARE5, 64'd0);
		put_simple(ACT_SPARE6, 64'd0);
		put_simple(ACT_SPARE7, 64'd0);
		// clamped order, order zero, zero-length segment
		build_entry(64'd0, -ONE_Q, 64'd0, 4'd15);
		build_entry(ONE_Q, 64'd0, ONE_Q, 4'd0);
		build_entry(2 * ONE_Q, ONE_Q, ONE_Q, 4'd3);
		put_simple(ACT_EVAL, 64'd0);
		put_simple(ACT_EVAL, 64'd0);
		put_simple(ACT_EVAL, ONE_Q >> 1);
		put_simple(ACT_EVAL, ONE_Q);
		put_simple(ACT_EVAL, ONE_Q + (ONE_Q >> 1));
		put_simple(ACT_EVAL, -5 * ONE_Q);
		put_simple(ACT_EVAL, SAT_MIN);
		put_simple(ACT_EVAL, SAT_MAX);
		put_simple(ACT_CLEAR, 64'd0);
		put_simple(ACT_EVAL, 64'd0);
		stimes.delete();

		run_phase(2, 4, 3, 1'b0, 30);
		run_phase(31, 1, 0, 1'b0, 6);
		run_phase(0, 4, 3, 1'b1, 25);
		run_phase(1, 3, 14, 1'b0, 15);

		drain();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
